// File: rtl/sktbs_pkg.sv
// ----------------------------------------------------------------------------
// sktbs_pkg: shared types and constants
// Widths, operation and status codes, and sequencer states for the sorted
// key table.
// ----------------------------------------------------------------------------
package sktbs_pkg;

    localparam int TABLE_DEPTH = 512;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 192;
    localparam int VAL_W       = 192;
    localparam int IN_W        = 2 + KEY_W + VAL_W;
    localparam int IN_BYTES_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W       = 2 + VAL_W + 9 + 10;
    localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_LOOKUP = 2'd1,
        FUNC_CLEAR  = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_DUP  = 2'd2,
        ST_FULL = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HIT_RD,
        S_HIT_CMP,
        S_SRCH,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_DECIDE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INS_WR,
        S_VAL_RD,
        S_VAL_WAIT,
        S_OUT
    } state_t;

    // Signed compare result of stored key against search key
    typedef enum logic [1:0] {
        CMP_LT = 2'd0,
        CMP_EQ = 2'd1,
        CMP_GT = 2'd2
    } cmp_t;

endpackage

// File: rtl/sktbs_key_cmp.sv
// ----------------------------------------------------------------------------
// sktbs_key_cmp: shared key comparator
// Registered signed compare of a stored 192-bit key against the search key,
// word 0 most significant.
// ----------------------------------------------------------------------------
module sktbs_key_cmp (
    input  logic                      clk,
    input  logic [sktbs_pkg::KEY_W-1:0] stored_key,
    input  logic [sktbs_pkg::KEY_W-1:0] search_key,
    output sktbs_pkg::cmp_t           result
);

    sktbs_pkg::cmp_t result_reg;
    sktbs_pkg::cmp_t result_next;
    logic [sktbs_pkg::KEY_W-1:0] a_biased;
    logic [sktbs_pkg::KEY_W-1:0] b_biased;

    // Flip each word's sign bit, then word 0 sits highest for an unsigned compare
    always_comb
    begin
        a_biased = {stored_key[63:0] ^ 64'h8000_0000_0000_0000,
                    stored_key[127:64] ^ 64'h8000_0000_0000_0000,
                    stored_key[191:128] ^ 64'h8000_0000_0000_0000};
        b_biased = {search_key[63:0] ^ 64'h8000_0000_0000_0000,
                    search_key[127:64] ^ 64'h8000_0000_0000_0000,
                    search_key[191:128] ^ 64'h8000_0000_0000_0000};
        if (a_biased == b_biased)
            result_next = sktbs_pkg::CMP_EQ;
        else if (a_biased < b_biased)
            result_next = sktbs_pkg::CMP_LT;
        else
            result_next = sktbs_pkg::CMP_GT;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

// File: rtl/sktbs_store.sv
// ----------------------------------------------------------------------------
// sktbs_store: key and value memory
// One entry per row: 192-bit key and 192-bit value, one write and one
// registered read port.
// ----------------------------------------------------------------------------
module sktbs_store (
    input  logic                                clk,
    input  logic                                wr_en,
    input  logic [sktbs_pkg::IDX_W-1:0]         wr_addr,
    input  logic [sktbs_pkg::KEY_W-1:0]         wr_key,
    input  logic [sktbs_pkg::VAL_W-1:0]         wr_val,
    input  logic [sktbs_pkg::IDX_W-1:0]         rd_addr,
    output logic [sktbs_pkg::KEY_W-1:0]         rd_key,
    output logic [sktbs_pkg::VAL_W-1:0]         rd_val
);

    logic [sktbs_pkg::KEY_W-1:0] key_mem [sktbs_pkg::TABLE_DEPTH];
    logic [sktbs_pkg::VAL_W-1:0] val_mem [sktbs_pkg::TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            val_mem[wr_addr] <= wr_val;
        end
        rd_key <= key_mem[rd_addr];
        rd_val <= val_mem[rd_addr];
    end

endmodule

// File: rtl/sorted_key_table_binary_search.sv
// Lookup: the last-hit entry is tried first and its value read out on a match, else a
// binary search runs; a search step is read, compare, update.
// Insert: binary search, then each entry above the slot is moved up one row, then the write.
// Clear and the unused code go straight to the result. One item at a time; s_tready is high only when idle
// with no result pending. Reset (rst_n, async low) empties the table and clears the
// last-hit index; memory contents are not cleared.
// ----------------------------------------------------------------------------
// sorted_key_table_binary_search: sorted key table top level
// Sequencer around one key memory and one shared comparator.
// ----------------------------------------------------------------------------
module sorted_key_table_binary_search (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // func, key_word0..2, value_word0..2 (from bit 0 up), zero pad
    input  logic [sktbs_pkg::IN_BYTES_W-1:0]      s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // status, found_word0..2, position, entry_count (from bit 0 up), zero pad
    output logic [sktbs_pkg::OUT_BYTES_W-1:0]     m_tdata
);

    localparam int IW = sktbs_pkg::IDX_W;
    localparam int CW = sktbs_pkg::CNT_W;

    sktbs_pkg::state_t state_reg, state_next;
    sktbs_pkg::func_t  func_reg;
    logic [sktbs_pkg::KEY_W-1:0] key_reg;
    logic [sktbs_pkg::VAL_W-1:0] val_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] last_reg, last_next;
    logic [CW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic          hit_reg, hit_next;
    logic [CW-1:0] pos_reg, pos_next;
    sktbs_pkg::status_t status_reg, status_next;
    logic [sktbs_pkg::VAL_W-1:0] found_reg, found_next;
    logic          out_valid_reg, out_valid_next;

    logic          wr_en;
    logic [IW-1:0] wr_addr, rd_addr;
    logic [sktbs_pkg::KEY_W-1:0] wr_key, rd_key;
    logic [sktbs_pkg::VAL_W-1:0] wr_val, rd_val;
    sktbs_pkg::cmp_t cmp_res;
    logic          in_acc;

    sktbs_store u_store (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_key(wr_key),
        .wr_val(wr_val), .rd_addr(rd_addr), .rd_key(rd_key), .rd_val(rd_val)
    );

    sktbs_key_cmp u_cmp (
        .clk(clk), .stored_key(rd_key), .search_key(key_reg), .result(cmp_res)
    );

    assign in_acc   = s_tvalid && s_tready;
    assign s_tready = (state_reg == sktbs_pkg::S_IDLE) && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(sktbs_pkg::OUT_BYTES_W - sktbs_pkg::OUT_W){1'b0}},
                       10'(count_reg), 9'(pos_reg), found_reg, status_reg};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sktbs_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    case (sktbs_pkg::func_t'(s_tdata[1:0]))
                        sktbs_pkg::FUNC_INSERT: state_next = sktbs_pkg::S_SRCH;
                        sktbs_pkg::FUNC_LOOKUP:
                            state_next = (CW'(last_reg) < count_reg) ?
                                         sktbs_pkg::S_HIT_RD : sktbs_pkg::S_SRCH;
                        default: state_next = sktbs_pkg::S_OUT;
                    endcase
                end
            end
            sktbs_pkg::S_HIT_RD:   state_next = sktbs_pkg::S_HIT_CMP;
            sktbs_pkg::S_HIT_CMP:
                state_next = (cmp_res == sktbs_pkg::CMP_EQ) ?
                             sktbs_pkg::S_VAL_WAIT : sktbs_pkg::S_SRCH;
            sktbs_pkg::S_SRCH:
                state_next = (lo_reg < hi_reg) ? sktbs_pkg::S_SRCH_RD
                                               : sktbs_pkg::S_DECIDE;
            sktbs_pkg::S_SRCH_RD:  state_next = sktbs_pkg::S_SRCH_CMP;
            sktbs_pkg::S_SRCH_CMP:
                state_next = (cmp_res == sktbs_pkg::CMP_EQ) ?
                             sktbs_pkg::S_DECIDE : sktbs_pkg::S_SRCH;
            sktbs_pkg::S_DECIDE:
            begin
                if (func_reg == sktbs_pkg::FUNC_LOOKUP)
                    state_next = hit_reg ? sktbs_pkg::S_VAL_RD : sktbs_pkg::S_OUT;
                else if (hit_reg || count_reg >= CW'(sktbs_pkg::TABLE_DEPTH))
                    state_next = sktbs_pkg::S_OUT;
                else if (count_reg > lo_reg)
                    state_next = sktbs_pkg::S_SHIFT_RD;
                else
                    state_next = sktbs_pkg::S_INS_WR;
            end
            sktbs_pkg::S_SHIFT_RD: state_next = sktbs_pkg::S_SHIFT_WR;
            sktbs_pkg::S_SHIFT_WR:
                state_next = (ptr_reg - 1'b1 > pos_reg) ?
                             sktbs_pkg::S_SHIFT_RD : sktbs_pkg::S_INS_WR;
            sktbs_pkg::S_INS_WR:   state_next = sktbs_pkg::S_OUT;
            sktbs_pkg::S_VAL_RD:   state_next = sktbs_pkg::S_VAL_WAIT;
            sktbs_pkg::S_VAL_WAIT: state_next = sktbs_pkg::S_OUT;
            sktbs_pkg::S_OUT:      state_next = sktbs_pkg::S_IDLE;
            default:               state_next = sktbs_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        count_next     = count_reg;
        last_next      = last_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        ptr_next       = ptr_reg;
        hit_next       = hit_reg;
        pos_next       = pos_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg;
        wr_en          = 1'b0;
        wr_addr        = pos_reg[IW-1:0];
        wr_key         = key_reg;
        wr_val         = val_reg;
        rd_addr        = mid_reg[IW-1:0];
        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;
        case (state_reg)
            sktbs_pkg::S_IDLE:
            begin
                // keep the last-hit entry on the read port so its key is ready at accept
                rd_addr = last_reg;
                if (in_acc)
                begin
                    lo_next     = '0;
                    hi_next     = count_reg;
                    hit_next    = 1'b0;
                    pos_next    = '0;
                    status_next = sktbs_pkg::ST_OK;
                    found_next  = '0;
                    mid_next    = CW'(last_reg);
                    if (sktbs_pkg::func_t'(s_tdata[1:0]) == sktbs_pkg::FUNC_CLEAR)
                    begin
                        count_next = '0;
                        last_next  = '0;
                    end
                end
            end
            sktbs_pkg::S_HIT_RD:   rd_addr = mid_reg[IW-1:0];
            sktbs_pkg::S_HIT_CMP:
            begin
                if (cmp_res == sktbs_pkg::CMP_EQ)
                begin
                    hit_next = 1'b1;
                    pos_next = mid_reg;
                end
            end
            sktbs_pkg::S_SRCH:
            begin
                mid_next = lo_reg + ((hi_reg - lo_reg) >> 1);
                rd_addr  = mid_next[IW-1:0];
            end
            sktbs_pkg::S_SRCH_RD:  rd_addr = mid_reg[IW-1:0];
            sktbs_pkg::S_SRCH_CMP:
            begin
                case (cmp_res)
                    sktbs_pkg::CMP_EQ:
                    begin
                        hit_next = 1'b1;
                        lo_next  = mid_reg;
                    end
                    sktbs_pkg::CMP_GT: hi_next = mid_reg;
                    default:           lo_next = mid_reg + 1'b1;
                endcase
            end
            sktbs_pkg::S_DECIDE:
            begin
                pos_next = lo_reg;
                ptr_next = count_reg;
                if (func_reg == sktbs_pkg::FUNC_LOOKUP)
                begin
                    if (hit_reg)
                        last_next = lo_reg[IW-1:0];
                    else
                        status_next = sktbs_pkg::ST_MISS;
                    if (!hit_reg)
                        pos_next = '0;
                end
                else if (hit_reg)
                    status_next = sktbs_pkg::ST_DUP;
                else if (count_reg >= CW'(sktbs_pkg::TABLE_DEPTH))
                begin
                    status_next = sktbs_pkg::ST_FULL;
                    pos_next    = '0;
                end
            end
            sktbs_pkg::S_SHIFT_RD: rd_addr = IW'(ptr_reg - 1'b1);
            sktbs_pkg::S_SHIFT_WR:
            begin
                wr_en    = 1'b1;
                wr_addr  = ptr_reg[IW-1:0];
                wr_key   = rd_key;
                wr_val   = rd_val;
                ptr_next = ptr_reg - 1'b1;
            end
            sktbs_pkg::S_INS_WR:
            begin
                wr_en      = 1'b1;
                count_next = count_reg + 1'b1;
            end
            sktbs_pkg::S_VAL_RD:   rd_addr = pos_reg[IW-1:0];
            sktbs_pkg::S_VAL_WAIT:
                if (hit_reg && func_reg == sktbs_pkg::FUNC_LOOKUP && state_reg ==
                    sktbs_pkg::S_VAL_WAIT)
                    found_next = rd_val;
            sktbs_pkg::S_OUT:      out_valid_next = 1'b1;
            default: ;
        endcase
        // last-hit path reads value at mid directly
        if (state_reg == sktbs_pkg::S_HIT_CMP)
            rd_addr = mid_reg[IW-1:0];
    end

    // Registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sktbs_pkg::S_IDLE;
            count_reg     <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            func_reg <= sktbs_pkg::func_t'(s_tdata[1:0]);
            key_reg  <= s_tdata[2 +: sktbs_pkg::KEY_W];
            val_reg  <= s_tdata[2 + sktbs_pkg::KEY_W +: sktbs_pkg::VAL_W];
        end
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        ptr_reg    <= ptr_next;
        hit_reg    <= hit_next;
        pos_reg    <= pos_next;
        status_reg <= status_next;
        found_reg  <= found_next;
    end

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: sorted key table self-checking bench
// Drives insert, lookup, clear and unused-code items with random gaps and output stalls,
// keeps a shadow sorted table to predict each result, and compares every
// returned item field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 5000000;

    typedef struct packed {
        logic [63:0]       v2;
        logic [63:0]       v1;
        logic [63:0]       v0;
        logic [63:0]       k2;
        logic [63:0]       k1;
        logic [63:0]       k0;
        sktbs_pkg::func_t  op;
    } table_req_t;

    typedef struct packed {
        logic [9:0]         count;
        logic [8:0]         pos;
        logic [63:0]        f2;
        logic [63:0]        f1;
        logic [63:0]        f0;
        sktbs_pkg::status_t st;
    } table_rsp_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [sktbs_pkg::IN_BYTES_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [sktbs_pkg::OUT_BYTES_W-1:0] m_tdata;

    sorted_key_table_binary_search i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Shadow table
    logic [191:0] shadow_keys [sktbs_pkg::TABLE_DEPTH];
    logic [191:0] shadow_vals [sktbs_pkg::TABLE_DEPTH];
    int           shadow_count;
    int           shadow_last_hit;

    table_req_t   pending_items[$];
    table_rsp_t   expected_rsps[$];
    logic [191:0] known_keys[$];

    int  mismatches;
    int  cycles;
    bit  stim_done;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Signed three-word compare: -1, 0, 1 of a against b
    function automatic int key_order(logic [191:0] a, logic [191:0] b);
        logic signed [63:0] x;
        logic signed [63:0] y;
        for (int w = 0; w < 3; w++)
        begin
            x = a[w*64 +: 64];
            y = b[w*64 +: 64];
            if (x < y) return -1;
            if (x > y) return 1;
        end
        return 0;
    endfunction

    function automatic bit shadow_find(logic [191:0] key, output int pos);
        int lo;
        int hi;
        int mid;
        int c;
        lo = 0;
        hi = shadow_count;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            c = key_order(shadow_keys[mid], key);
            if (c == 0)
            begin
                pos = mid;
                return 1'b1;
            end
            if (c > 0) hi = mid;
            else lo = mid + 1;
        end
        pos = lo;
        return 1'b0;
    endfunction

    function automatic table_rsp_t predict_table(table_req_t it);
        table_rsp_t   r;
        logic [191:0] key;
        int           pos;
        key = {it.k2, it.k1, it.k0};
        r = '0;
        r.st = sktbs_pkg::ST_OK;
        case (it.op)
            sktbs_pkg::FUNC_INSERT:
            begin
                if (shadow_find(key, pos))
                begin
                    r.st = sktbs_pkg::ST_DUP;
                    r.pos = pos[8:0];
                end
                else if (shadow_count >= sktbs_pkg::TABLE_DEPTH)
                    r.st = sktbs_pkg::ST_FULL;
                else
                begin
                    for (int i = shadow_count; i > pos; i--)
                    begin
                        shadow_keys[i] = shadow_keys[i-1];
                        shadow_vals[i] = shadow_vals[i-1];
                    end
                    shadow_keys[pos] = key;
                    shadow_vals[pos] = {it.v2, it.v1, it.v0};
                    shadow_count++;
                    r.pos = pos[8:0];
                end
            end
            sktbs_pkg::FUNC_LOOKUP:
            begin
                if (shadow_last_hit < shadow_count &&
                    key_order(shadow_keys[shadow_last_hit], key) == 0)
                    pos = shadow_last_hit;
                else if (shadow_find(key, pos))
                    shadow_last_hit = pos;
                else
                    pos = -1;
                if (pos < 0)
                    r.st = sktbs_pkg::ST_MISS;
                else
                begin
                    r.pos = pos[8:0];
                    {r.f2, r.f1, r.f0} = shadow_vals[pos];
                end
            end
            sktbs_pkg::FUNC_CLEAR:
            begin
                shadow_count = 0;
                shadow_last_hit = 0;
            end
            default: ;
        endcase
        r.count = shadow_count[9:0];
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Small word values make ties in the upper words common
    function automatic logic [63:0] key_word();
        case ($urandom_range(0, 5))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7fff_ffff_ffff_ffff;
            2: return rand64();
            default: return 64'($signed($urandom_range(0, 6)) - 3);
        endcase
    endfunction

    function automatic table_req_t make_item(sktbs_pkg::func_t op, logic [191:0] key);
        table_req_t it;
        it.op = op;
        {it.k2, it.k1, it.k0} = key;
        it.v0 = rand64();
        it.v1 = rand64();
        it.v2 = rand64();
        return it;
    endfunction

    function automatic logic [191:0] fresh_key();
        return {key_word(), key_word(), key_word()};
    endfunction

    task automatic queue_item(table_req_t it);
        if (it.op == sktbs_pkg::FUNC_INSERT) known_keys.push_back({it.k2, it.k1, it.k0});
        if (it.op == sktbs_pkg::FUNC_CLEAR) known_keys.delete();
        pending_items.push_back(it);
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Stimulus
    initial
    begin
        table_req_t   it;
        logic [191:0] k;
        int           r;
        // Directed: empty lookup, extremes, duplicate, stale hit, unused code, clear
        queue_item(make_item(sktbs_pkg::FUNC_LOOKUP, '0));
        queue_item(make_item(sktbs_pkg::FUNC_INSERT, {3{64'h8000_0000_0000_0000}}));
        queue_item(make_item(sktbs_pkg::FUNC_INSERT, {3{64'h7fff_ffff_ffff_ffff}}));
        queue_item(make_item(sktbs_pkg::FUNC_INSERT, '0));
        queue_item(make_item(sktbs_pkg::FUNC_INSERT, {3{64'hffff_ffff_ffff_ffff}}));
        queue_item(make_item(sktbs_pkg::FUNC_INSERT,
                             {64'h1, 64'h0, 64'hffff_ffff_ffff_ffff}));
        it = make_item(sktbs_pkg::FUNC_INSERT, '0);
        it.v0 = '1; it.v1 = '1; it.v2 = '1;
        queue_item(it);
        queue_item(make_item(sktbs_pkg::FUNC_LOOKUP, '0));
        queue_item(make_item(sktbs_pkg::FUNC_LOOKUP, '0));
        queue_item(make_item(sktbs_pkg::FUNC_LOOKUP, {3{64'h7fff_ffff_ffff_ffff}}));
        queue_item(make_item(sktbs_pkg::FUNC_LOOKUP, {3{64'h8000_0000_0000_0000}}));
        queue_item(make_item(sktbs_pkg::FUNC_LOOKUP, {64'h1, 64'h0, 64'h0}));
        it = make_item(sktbs_pkg::FUNC_NONE, {3{64'h5555_aaaa_5555_aaaa}});
        it.v0 = '1; it.v1 = '1; it.v2 = '1;
        queue_item(it);
        queue_item(make_item(sktbs_pkg::FUNC_CLEAR, '1));
        queue_item(make_item(sktbs_pkg::FUNC_LOOKUP, {3{64'h8000_0000_0000_0000}}));
        queue_item(make_item(sktbs_pkg::FUNC_INSERT, {3{64'h5}}));
        queue_item(make_item(sktbs_pkg::FUNC_LOOKUP, {3{64'h5}}));
        // Fill to full, then overflow and duplicate at full
        for (int i = 0; i < sktbs_pkg::TABLE_DEPTH; i++)
            queue_item(make_item(sktbs_pkg::FUNC_INSERT,
                                 {64'(i * 7 - 1000), rand64(), rand64()}));
        queue_item(make_item(sktbs_pkg::FUNC_INSERT, {64'h7fff_ffff_ffff_ffff, 128'h0}));
        queue_item(make_item(sktbs_pkg::FUNC_INSERT, known_keys[3]));
        queue_item(make_item(sktbs_pkg::FUNC_LOOKUP, known_keys[100]));
        queue_item(make_item(sktbs_pkg::FUNC_LOOKUP, known_keys[100]));
        queue_item(make_item(sktbs_pkg::FUNC_CLEAR, '0));
        // Random mix, mostly hitting keys already inserted
        for (int n = 0; n < 30; n++)
        begin
            r = $urandom_range(0, 99);
            if (known_keys.size() > 0 && $urandom_range(0, 2) != 0)
                k = known_keys[$urandom_range(0, known_keys.size() - 1)];
            else
                k = fresh_key();
            if (r < 40)      queue_item(make_item(sktbs_pkg::FUNC_INSERT, k));
            else if (r < 94) queue_item(make_item(sktbs_pkg::FUNC_LOOKUP, k));
            else if (r < 97) queue_item(make_item(sktbs_pkg::FUNC_NONE, k));
            else             queue_item(make_item(sktbs_pkg::FUNC_CLEAR, k));
        end
        stim_done = 1'b1;
    end

    // Reset and driver
    int send_gap;
    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        send_gap = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                expected_rsps.push_back(
                    predict_table(table_req_t'(s_tdata[sktbs_pkg::IN_W-1:0])));
                void'(pending_items.pop_front());
                send_gap = gap_len();
            end
            if ((s_tvalid && !s_tready) ||
                (send_gap == 0 && pending_items.size() > 0 &&
                 !(s_tvalid && s_tready && pending_items.size() == 0)))
            begin
                if (!(s_tvalid && !s_tready))
                    s_tdata <= sktbs_pkg::IN_BYTES_W'(pending_items[0]);
                s_tvalid <= pending_items.size() > 0;
            end
            else
            begin
                s_tvalid <= 1'b0;
                if (send_gap > 0) send_gap--;
            end
        end
    end

    // Monitor and output stall
    always @(posedge clk)
    begin
        table_rsp_t got;
        table_rsp_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = table_rsp_t'(m_tdata[sktbs_pkg::OUT_W-1:0]);
                if (expected_rsps.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item %h", got);
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: st %0d/%0d f %h %h %h / %h %h %h",
                                      " pos %0d/%0d cnt %0d/%0d"},
                                want.st, got.st, want.f0, want.f1, want.f2,
                                got.f0, got.f1, got.f2, want.pos, got.pos,
                                want.count, got.count);
                    end
                end
            end
            m_tready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 3) == 0);
        end
    end

    // End of run and cycle limit
    initial
    begin
        mismatches = 0;
        cycles = 0;
        wait (stim_done);
        while (cycles < CYCLE_LIMIT &&
               (pending_items.size() > 0 || expected_rsps.size() > 0 || s_tvalid))
        begin
            @(posedge clk);
            cycles++;
        end
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
        end
        else
        begin
            repeat (50) @(posedge clk);
            if (mismatches == 0 && expected_rsps.size() == 0)
                $display("tb: success");
            else
                $display("tb: failure");
        end
        $finish;
    end

endmodule
